### design/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types, constants and helpers for the masked byte pattern search.
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int WIN_DEPTH   = MAX_PATTERN - 1;
  localparam int LEN_W       = 5;
  localparam int LANE_W      = 4;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int OFF_W       = 32;
  localparam int RES_DEPTH   = 2;

  typedef enum logic [1:0] {
    MODE_FIRST      = 2'd0,
    MODE_LAST       = 2'd1,
    MODE_ANCH_START = 2'd2,
    MODE_ANCH_END   = 2'd3
  } search_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LO   = 3'd0,
    REG_PAT_HI   = 3'd1,
    REG_CARE_LO  = 3'd2,
    REG_CARE_HI  = 3'd3,
    REG_PAT_LEN  = 3'd4,
    REG_MODE     = 3'd5,
    REG_BASE     = 3'd6,
    REG_UNUSED   = 3'd7
  } cfg_reg_t;

  // per-cell slice of the pattern
  typedef struct packed {
    logic [7:0] pattern;
    logic [7:0] care;
    logic       active;
  } lane_cfg_t;

  // control broadcast to every cell
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic             found;
    logic [OFF_W-1:0] match_offset;
    logic [LEN_W-1:0] match_length;
  } result_t;

  // pick byte idx out of a 128-bit pattern or care word
  function automatic logic [7:0] lane_byte(input logic [2*CFG_DATA_W-1:0] vec,
                                           input logic [LANE_W-1:0] idx);
    return vec[{idx, 3'b000} +: 8];
  endfunction

  // clamp the programmed length into 1..MAX_PATTERN
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] n);
    logic [LEN_W-1:0] r;
    r = n;
    if (r == '0) r = LEN_W'(1);
    if (r > LEN_W'(MAX_PATTERN)) r = LEN_W'(MAX_PATTERN);
    return r;
  endfunction

endpackage

### design/mbps_in_if.sv
// ----------------------------------------------------------------------------
// mbps_in_if
// Request channel carrying one region byte and its end-of-region flag.
// ----------------------------------------------------------------------------
interface mbps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       region_end;

  modport source (output valid, output data_byte, output region_end, input ready);
  modport sink   (input valid, input data_byte, input region_end, output ready);
endinterface

### design/mbps_out_if.sv
// ----------------------------------------------------------------------------
// mbps_out_if
// Result channel carrying the search outcome of one region.
// ----------------------------------------------------------------------------
interface mbps_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] match_offset;
  logic [4:0]  match_length;

  modport source (output valid, output found, output match_offset, output match_length,
                  input ready);
  modport sink   (input valid, input found, input match_offset, input match_length,
                  output ready);
endinterface

### design/mbps_cell.sv
// ----------------------------------------------------------------------------
// mbps_cell
// One window byte: holds it, passes it on, and checks it against its pattern lane.
// ----------------------------------------------------------------------------
module mbps_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  mbps_pkg::cell_ctrl_t   ctrl,
  input  logic [7:0]             byte_in,
  input  mbps_pkg::lane_cfg_t    lane,
  output logic [7:0]             byte_out,
  output logic                   match
);
  import mbps_pkg::*;

  logic [7:0] held;

  always_ff @(posedge clk) begin
    if (rst || (ctrl.shift && ctrl.clear)) begin
      held <= '0;
    end else if (ctrl.shift) begin
      held <= byte_in;
    end
  end

  // unused lanes always agree
  assign match    = !lane.active || ((held & lane.care) == (lane.pattern & lane.care));
  assign byte_out = held;

endmodule

### design/masked_byte_pattern_search.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_search
// Streams region bytes through a row of window cells and reports one masked
// pattern match per region under the configured search mode.
// ----------------------------------------------------------------------------
// throughput: one byte per cycle while the result buffer has room, set by the window shift and
// the parallel lane compares in the cell row
// latency: the result is visible the cycle after the last byte is accepted
// a two-entry result buffer lets bytes keep flowing while a result waits
// reset: config registers to defaults (length 1, first-match mode), window,
// byte count and recorded hit cleared, result buffer emptied
module masked_byte_pattern_search (
  input  logic                                clk,
  input  logic                                rst,
  mbps_in_if.sink                             in_req,
  mbps_out_if.source                          out_res,
  input  logic                                cfg_we,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mbps_pkg::*;

  // configuration registers
  logic [CFG_DATA_W-1:0] pat_lo, pat_hi, care_lo, care_hi;
  logic [LEN_W-1:0]      pat_len;
  search_mode_t          mode;
  logic [OFF_W-1:0]      region_base;

  // region state
  logic [OFF_W-1:0] byte_count;
  logic             hit_seen;
  logic [OFF_W-1:0] hit_offset;

  // result buffer
  result_t          res_slot [RES_DEPTH];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       fill;

  logic in_acc, out_acc, push;

  logic [LEN_W-1:0]      len_eff;
  logic [2*CFG_DATA_W-1:0] pat_all, care_all;

  logic [7:0]            cell_q     [WIN_DEPTH];
  logic [WIN_DEPTH-1:0]  cell_match;
  lane_cfg_t             cell_lane  [WIN_DEPTH];
  cell_ctrl_t            ctrl;

  logic                  head_match;
  logic [7:0]            head_pat, head_care;
  logic [OFF_W-1:0]      count_next, cand_off;
  logic                  cand, hit, take;
  logic                  hit_seen_upd;
  logic [OFF_W-1:0]      hit_offset_upd;
  result_t               res_new;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_lo      <= '0;
      pat_hi      <= '0;
      care_lo     <= '0;
      care_hi     <= '0;
      pat_len     <= LEN_W'(1);
      mode        <= MODE_FIRST;
      region_base <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PAT_LO:  pat_lo      <= cfg_data;
        REG_PAT_HI:  pat_hi      <= cfg_data;
        REG_CARE_LO: care_lo     <= cfg_data;
        REG_CARE_HI: care_hi     <= cfg_data;
        REG_PAT_LEN: pat_len     <= cfg_data[LEN_W-1:0];
        REG_MODE:    mode        <= search_mode_t'(cfg_data[1:0]);
        REG_BASE:    region_base <= cfg_data[OFF_W-1:0];
        default:     ;  // writes past the register list are dropped
      endcase
    end
  end

  assign len_eff  = eff_len(pat_len);
  assign pat_all  = {pat_hi, pat_lo};
  assign care_all = {care_hi, care_lo};

  // ---------------- handshakes ----------------
  assign in_req.ready = (fill != 2'(RES_DEPTH));
  assign in_acc       = in_req.valid && in_req.ready;
  assign out_acc      = out_res.valid && out_res.ready;
  assign push         = in_acc && in_req.region_end;

  // every cell shifts on an accepted byte, and the last byte of a region
  // wipes the whole window for the next one
  assign ctrl.shift = in_acc;
  assign ctrl.clear = in_req.region_end;

  // ---------------- window cell row ----------------
  // cell k holds the byte k+1 positions back and lines up with pattern lane
  // len-2-k; cells beyond the pattern are switched off
  for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_cell
    logic [LEN_W-1:0] lane_sel;
    assign lane_sel = len_eff - LEN_W'(k + 2);

    assign cell_lane[k].pattern = lane_byte(pat_all, lane_sel[LANE_W-1:0]);
    assign cell_lane[k].care    = lane_byte(care_all, lane_sel[LANE_W-1:0]);
    assign cell_lane[k].active  = (LEN_W'(k + 2) <= len_eff);

    mbps_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .byte_in  ((k == 0) ? in_req.data_byte : cell_q[(k == 0) ? 0 : k - 1]),
      .lane     (cell_lane[k]),
      .byte_out (cell_q[k]),
      .match    (cell_match[k])
    );
  end

  // the incoming byte always lines up with the last pattern lane
  logic [LEN_W-1:0] head_sel;
  assign head_sel   = len_eff - LEN_W'(1);
  assign head_pat   = lane_byte(pat_all, head_sel[LANE_W-1:0]);
  assign head_care  = lane_byte(care_all, head_sel[LANE_W-1:0]);
  assign head_match = ((in_req.data_byte & head_care) == (head_pat & head_care));

  // ---------------- match decision ----------------
  assign count_next = byte_count + OFF_W'(1);
  assign cand       = (count_next >= OFF_W'(len_eff));
  assign hit        = cand && head_match && (&cell_match);
  assign cand_off   = region_base + (count_next - OFF_W'(len_eff));

  always_comb begin
    unique case (mode)
      MODE_FIRST:      take = !hit_seen;
      MODE_LAST:       take = 1'b1;
      MODE_ANCH_START: take = (count_next == OFF_W'(len_eff));
      MODE_ANCH_END:   take = in_req.region_end;
      default:         take = 1'b0;
    endcase
  end

  always_comb begin
    hit_seen_upd   = hit_seen;
    hit_offset_upd = hit_offset;
    if (hit && take) begin
      hit_seen_upd   = 1'b1;
      hit_offset_upd = cand_off;
    end
  end

  // result of the region closing on this byte
  assign res_new.found        = hit_seen_upd;
  assign res_new.match_offset = hit_seen_upd ? hit_offset_upd : '0;
  assign res_new.match_length = hit_seen_upd ? len_eff : '0;

  // region bookkeeping, cleared after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      hit_seen   <= 1'b0;
      hit_offset <= '0;
    end else if (in_acc) begin
      if (in_req.region_end) begin
        byte_count <= '0;
        hit_seen   <= 1'b0;
        hit_offset <= '0;
      end else begin
        byte_count <= count_next;
        hit_seen   <= hit_seen_upd;
        hit_offset <= hit_offset_upd;
      end
    end
  end

  // ---------------- result buffer ----------------
  always_ff @(posedge clk) begin
    if (push) begin
      res_slot[wr_ptr] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push)    wr_ptr <= !wr_ptr;
      if (out_acc) rd_ptr <= !rd_ptr;
      unique case ({push, out_acc})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  assign out_res.valid        = (fill != '0);
  assign out_res.found        = res_slot[rd_ptr].found;
  assign out_res.match_offset = res_slot[rd_ptr].match_offset;
  assign out_res.match_length = res_slot[rd_ptr].match_length;

  // ---------------- assertions ----------------
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= 2'(RES_DEPTH))
    else $error("result buffer overfilled");

  a_region_clears: assert property (@(posedge clk) disable iff (rst)
    push |=> (byte_count == '0) && !hit_seen)
    else $error("region state not cleared after last byte");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    (fill == '0) ##1 (fill != '0) |-> $past(push))
    else $error("result appeared without a closing byte");

  a_no_hit_zero: assert property (@(posedge clk) disable iff (rst)
    (out_res.valid && !out_res.found) |-> (out_res.match_offset == '0) &&
                                          (out_res.match_length == '0))
    else $error("non-zero offset or length on a miss");

endmodule
